[rtl/llur_pkg.sv]
`default_nettype none
package llur_pkg;

    localparam int MAX_WIDTH_DEF = 16384;

    // quotient bits of the normalising divide, one per stage
    localparam int DIV_BITS = 31;
    // operand capture, one stage per quotient bit, saturation stage
    localparam int DIV_LAT  = DIV_BITS + 2;
    // powers, terms, sum, difference, magnitude, scale, source column
    localparam int POLY_LAT = 15;

    localparam logic [30:0] SAT_MAG = 31'h7FFF_FFFF;

    localparam logic [2:0] REG_CENTER_COL   = 3'd0;
    localparam logic [2:0] REG_FOCAL_LEN    = 3'd1;
    localparam logic [2:0] REG_COEF_CUBIC   = 3'd2;
    localparam logic [2:0] REG_COEF_QUINTIC = 3'd3;
    localparam logic [2:0] REG_COEF_SQUARE  = 3'd4;
    localparam logic [2:0] REG_LINE_WIDTH   = 3'd5;

    localparam logic [31:0] CENTER_COL_RST = 32'd536870912;
    localparam logic [31:0] FOCAL_LEN_RST  = 32'd1073741824;
    localparam logic [14:0] LINE_WIDTH_RST = 15'd16384;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        opcode;
        logic [13:0] column;
        logic [7:0]  pixel;
    } tag_t;

endpackage
`default_nettype wire

[rtl/llur_dly.sv]
`default_nettype none
module llur_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] sr_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                sr_reg[i] <= '0;
            end
        end else if (en) begin
            sr_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[DEPTH-1];

endmodule
`default_nettype wire

[rtl/llur_mul.sv]
`default_nettype none
// floor(a * b / 2^28), split into a low 32x32 and a narrow high product
module llur_mul #(
    parameter int AW = 33,
    parameter int RW = 34
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [AW-1:0] a,
    input  wire logic [31:0]   b,
    output logic      [RW-1:0] p
);

    localparam int HW = AW - 32;
    localparam int SW = HW + 37;

    logic [63:0]      lo_reg;
    logic [HW+31:0]   hi_reg;
    logic [RW-1:0]    p_reg;
    logic [SW-1:0]    sum;

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= 64'(a[31:0]) * 64'(b);
            hi_reg <= (HW+32)'(a[AW-1:32]) * (HW+32)'(b);
        end
    end

    assign sum = SW'({hi_reg, 4'b0000}) + SW'(lo_reg[63:28]);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= sum[RW-1:0];
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

[rtl/llur_div.sv]
`default_nettype none
// n = (c - vc) / fy in q3.28 magnitude, restoring divide one bit per stage
module llur_div (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [13:0] column,
    input  wire logic [31:0] center_col,
    input  wire logic [31:0] focal_len,
    output logic      [30:0] nmag,
    output logic             nneg
);

    localparam int NB = llur_pkg::DIV_BITS;

    logic [32:0] cq;
    logic [32:0] cc;
    logic        dneg;
    logic [32:0] diff;
    logic        sat;
    logic [32:0] fy;

    logic [31:0] dmag_reg;
    logic        dneg_reg;
    logic        sat_reg;

    logic [31:0] r_reg    [NB];
    logic [30:0] q_reg    [NB];
    logic [2:0]  lo_reg   [NB];
    logic        sneg_reg [NB];
    logic        ssat_reg [NB];

    logic [30:0] nmag_reg;
    logic        nneg_reg;

    assign cq   = 33'({column, 16'h0000});
    assign cc   = {1'b0, center_col};
    assign dneg = cq < cc;
    assign diff = dneg ? (cc - cq) : (cq - cc);
    // quotient reaches 2^31 exactly when dmag >= 8 * fy
    assign sat  = (diff[31:0] != 32'd0) &&
                  ({4'b0000, diff[31:0]} >= {1'b0, focal_len, 3'b000});
    assign fy   = {1'b0, focal_len};

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag_reg <= diff[31:0];
            dneg_reg <= dneg;
            sat_reg  <= sat;
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_bit
        logic [31:0] r_in;
        logic [30:0] q_in;
        logic [2:0]  lo_in;
        logic        neg_in;
        logic        sat_in;
        logic        nbit;
        logic [32:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign r_in   = {3'b000, dmag_reg[31:3]};
            assign q_in   = '0;
            assign lo_in  = dmag_reg[2:0];
            assign neg_in = dneg_reg;
            assign sat_in = sat_reg;
        end else begin : g_next
            assign r_in   = r_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign neg_in = sneg_reg[k-1];
            assign sat_in = ssat_reg[k-1];
        end

        // dividend bits below the low three of dmag are zero
        if (k <= 2) begin : g_dbit
            assign nbit = lo_in[2-k];
        end else begin : g_zbit
            assign nbit = 1'b0;
        end

        assign trial = {r_in, nbit};
        assign ge    = trial >= fy;

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]    <= ge ? 32'(trial - fy) : trial[31:0];
                q_reg[k]    <= {q_in[29:0], ge};
                lo_reg[k]   <= lo_in;
                sneg_reg[k] <= neg_in;
                ssat_reg[k] <= sat_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nmag_reg <= ssat_reg[NB-1] ? llur_pkg::SAT_MAG : q_reg[NB-1];
            nneg_reg <= sneg_reg[NB-1] && (ssat_reg[NB-1] || (q_reg[NB-1] != 31'd0));
        end
    end

    assign nmag = nmag_reg;
    assign nneg = nneg_reg;

endmodule
`default_nettype wire

[rtl/llur_poly.sv]
`default_nettype none
// distortion polynomial, rescale and source column
module llur_poly #(
    parameter int MAX_WIDTH = llur_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic [30:0]                  nmag,
    input  wire logic                         nneg,
    input  wire logic [31:0]                  center_col,
    input  wire logic [31:0]                  focal_len,
    input  wire logic [31:0]                  coef_cubic,
    input  wire logic [31:0]                  coef_quintic,
    input  wire logic [31:0]                  coef_square,
    input  wire logic [14:0]                  line_width,
    output logic      [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic                              rd_in_range
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [21:0] MAXW = 22'(MAX_WIDTH);

    logic [31:0] kc_mag;
    logic [31:0] kq_mag;
    logic [31:0] ks_mag;

    logic [30:0] n_d2;
    logic [30:0] n_d4;
    logic [30:0] n_d6;
    logic [31:0] nx_d10;

    logic [33:0] m2;
    logic [36:0] m3;
    logic [39:0] m4;
    logic [42:0] m5;
    logic [45:0] t5;
    logic [39:0] t3;
    logic [39:0] t3_d;
    logic [36:0] t2;
    logic [36:0] t2_d;

    logic        neg3;
    logic        neg5;
    logic        neg2;
    logic [47:0] s3;
    logic [47:0] s5;
    logic [47:0] s2;

    logic [47:0] sum_reg;
    logic [30:0] n11_reg;
    logic        nneg11_reg;
    logic [48:0] np_reg;
    logic [48:0] np_abs;
    logic        npneg_reg;
    logic [30:0] npmag_reg;
    logic [62:0] prod_reg;
    logic        pneg_reg;

    logic [36:0] pmag_x;
    logic [36:0] u;
    logic [20:0] src;
    logic        ok;

    logic [AW-1:0] addr_reg;
    logic          ok_reg;

    assign kc_mag = coef_cubic[31]   ? (32'd0 - coef_cubic)   : coef_cubic;
    assign kq_mag = coef_quintic[31] ? (32'd0 - coef_quintic) : coef_quintic;
    assign ks_mag = coef_square[31]  ? (32'd0 - coef_square)  : coef_square;

    llur_dly #(.WIDTH(31), .DEPTH(2)) u_n2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(nmag), .dout(n_d2)
    );
    llur_dly #(.WIDTH(31), .DEPTH(2)) u_n4 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(n_d2), .dout(n_d4)
    );
    llur_dly #(.WIDTH(31), .DEPTH(2)) u_n6 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(n_d4), .dout(n_d6)
    );
    llur_dly #(.WIDTH(32), .DEPTH(10)) u_n10 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din({nneg, nmag}), .dout(nx_d10)
    );

    llur_mul #(.AW(33), .RW(34)) u_m2 (
        .aclk(aclk), .en(en), .a(33'(nmag)), .b({1'b0, nmag}), .p(m2)
    );
    llur_mul #(.AW(34), .RW(37)) u_m3 (
        .aclk(aclk), .en(en), .a(m2), .b({1'b0, n_d2}), .p(m3)
    );
    llur_mul #(.AW(37), .RW(40)) u_m4 (
        .aclk(aclk), .en(en), .a(m3), .b({1'b0, n_d4}), .p(m4)
    );
    llur_mul #(.AW(40), .RW(43)) u_m5 (
        .aclk(aclk), .en(en), .a(m4), .b({1'b0, n_d6}), .p(m5)
    );
    llur_mul #(.AW(43), .RW(46)) u_t5 (
        .aclk(aclk), .en(en), .a(m5), .b(kq_mag), .p(t5)
    );
    llur_mul #(.AW(37), .RW(40)) u_t3 (
        .aclk(aclk), .en(en), .a(m3), .b(kc_mag), .p(t3)
    );
    llur_mul #(.AW(34), .RW(37)) u_t2 (
        .aclk(aclk), .en(en), .a(m2), .b(ks_mag), .p(t2)
    );

    // align the cubic and square terms with the fifth order term
    llur_dly #(.WIDTH(40), .DEPTH(4)) u_t3d (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(t3), .dout(t3_d)
    );
    llur_dly #(.WIDTH(37), .DEPTH(6)) u_t2d (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(t2), .dout(t2_d)
    );

    assign neg3 = coef_cubic[31] ^ nx_d10[31];
    assign neg5 = coef_quintic[31] ^ nx_d10[31];
    assign neg2 = coef_square[31];
    assign s3 = neg3 ? (48'd0 - 48'(t3_d)) : 48'(t3_d);
    assign s5 = neg5 ? (48'd0 - 48'(t5))   : 48'(t5);
    assign s2 = neg2 ? (48'd0 - 48'(t2_d)) : 48'(t2_d);

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg    <= s3 + s5 + s2;
            n11_reg    <= nx_d10[30:0];
            nneg11_reg <= nx_d10[31];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            np_reg <= (nneg11_reg ? (49'd0 - 49'(n11_reg)) : 49'(n11_reg))
                      - {sum_reg[47], sum_reg};
        end
    end

    assign np_abs = np_reg[48] ? (49'd0 - np_reg) : np_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            npneg_reg <= np_reg[48];
            npmag_reg <= (np_abs > 49'(llur_pkg::SAT_MAG)) ? llur_pkg::SAT_MAG
                                                           : np_abs[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 63'(focal_len) * 63'(npmag_reg);
            pneg_reg <= npneg_reg;
        end
    end

    assign pmag_x = 37'(prod_reg[62:28]);
    assign u      = pneg_reg ? (37'(center_col) - pmag_x) : (37'(center_col) + pmag_x);
    assign src    = u[36:16];
    assign ok     = !u[36] && (22'(src) < 22'(line_width)) && (22'(src) < MAXW);

    always_ff @(posedge aclk) begin
        if (en) begin
            addr_reg <= src[AW-1:0];
            ok_reg   <= ok;
        end
    end

    assign rd_addr     = addr_reg;
    assign rd_in_range = ok_reg;

endmodule
`default_nettype wire

[rtl/llur_lookup.sv]
`default_nettype none
// line store: writes in item order, the registered read drives the result
module llur_lookup #(
    parameter int MAX_WIDTH = llur_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire llur_pkg::tag_t               tag,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  wire logic                         rd_in_range,
    output logic                              out_valid,
    output logic      [7:0]                   pixel_out,
    output logic                              in_range
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [21:0] MAXW = 22'(MAX_WIDTH);

    logic [7:0]  mem [MAX_WIDTH];
    logic [21:0] wcol;
    logic        wr;

    logic        out_valid_reg;
    logic        in_range_reg;
    logic [7:0]  rd_reg;

    assign wcol = 22'(tag.column);
    assign wr   = en && tag.valid && (tag.opcode == llur_pkg::OP_WRITE) && (wcol < MAXW);

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[wcol[AW-1:0]] <= tag.pixel;
        end
        if (en && rd_in_range) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= tag.valid && (tag.opcode == llur_pkg::OP_READ);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_range_reg <= rd_in_range;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_range  = in_range_reg;
    assign pixel_out = in_range_reg ? rd_reg : 8'h00;

    a_write_no_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (en && tag.valid && (tag.opcode == llur_pkg::OP_WRITE)) |=> !out_valid_reg)
        else $error("write item produced a result");

    a_read_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (en && tag.valid && (tag.opcode == llur_pkg::OP_READ)) |=> out_valid_reg)
        else $error("read item lost at the line store");

    a_hold_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        (!en) |=> ($stable(in_range_reg) && out_valid_reg))
        else $error("result changed during stall");

endmodule
`default_nettype wire

[rtl/line_lens_undistort_remap_core.sv]
// path from input transfer to result: the 33-stage divider, then the 15-stage
//   polynomial and rescale path, then the line store read
// throughput: one item per cycle; a stalled result holds the whole pipeline
// write items update the line store in order and give no result
// reset clears valid bits and loads register defaults; the line store is not cleared
`default_nettype none
module line_lens_undistort_remap_core #(
    parameter int MAX_WIDTH = llur_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [13:0] s_column,
    input  wire logic [7:0]  s_pixel_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_pixel_out,
    output logic             m_in_range
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int TW    = $bits(llur_pkg::tag_t);
    localparam int TDEPTH = llur_pkg::DIV_LAT + llur_pkg::POLY_LAT;

    logic [31:0] center_col_reg;
    logic [31:0] focal_len_reg;
    logic [31:0] coef_cubic_reg;
    logic [31:0] coef_quintic_reg;
    logic [31:0] coef_square_reg;
    logic [14:0] line_width_reg;

    logic           pipe_en;
    llur_pkg::tag_t tag_in;
    logic [TW-1:0]  tag_vec;
    llur_pkg::tag_t tag_out;

    logic [30:0]   nmag;
    logic          nneg;
    logic [AW-1:0] rd_addr;
    logic          rd_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_col_reg   <= llur_pkg::CENTER_COL_RST;
            focal_len_reg    <= llur_pkg::FOCAL_LEN_RST;
            coef_cubic_reg   <= '0;
            coef_quintic_reg <= '0;
            coef_square_reg  <= '0;
            line_width_reg   <= llur_pkg::LINE_WIDTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                llur_pkg::REG_CENTER_COL:   center_col_reg   <= cfg_wdata;
                llur_pkg::REG_FOCAL_LEN:    focal_len_reg    <= cfg_wdata;
                llur_pkg::REG_COEF_CUBIC:   coef_cubic_reg   <= cfg_wdata;
                llur_pkg::REG_COEF_QUINTIC: coef_quintic_reg <= cfg_wdata;
                llur_pkg::REG_COEF_SQUARE:  coef_square_reg  <= cfg_wdata;
                llur_pkg::REG_LINE_WIDTH:   line_width_reg   <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // the pipeline moves unless a result waits untaken
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    assign tag_in = '{valid: s_valid, opcode: s_opcode, column: s_column, pixel: s_pixel_in};

    llur_dly #(.WIDTH(TW), .DEPTH(TDEPTH)) u_tag (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .din(tag_in), .dout(tag_vec)
    );
    assign tag_out = llur_pkg::tag_t'(tag_vec);

    llur_div u_div (
        .aclk(aclk),
        .en(pipe_en),
        .column(s_column),
        .center_col(center_col_reg),
        .focal_len(focal_len_reg),
        .nmag(nmag),
        .nneg(nneg)
    );

    llur_poly #(.MAX_WIDTH(MAX_WIDTH)) u_poly (
        .aclk(aclk),
        .aresetn(aresetn),
        .en(pipe_en),
        .nmag(nmag),
        .nneg(nneg),
        .center_col(center_col_reg),
        .focal_len(focal_len_reg),
        .coef_cubic(coef_cubic_reg),
        .coef_quintic(coef_quintic_reg),
        .coef_square(coef_square_reg),
        .line_width(line_width_reg),
        .rd_addr(rd_addr),
        .rd_in_range(rd_in_range)
    );

    llur_lookup #(.MAX_WIDTH(MAX_WIDTH)) u_lookup (
        .aclk(aclk),
        .aresetn(aresetn),
        .en(pipe_en),
        .tag(tag_out),
        .rd_addr(rd_addr),
        .rd_in_range(rd_in_range),
        .out_valid(m_valid),
        .pixel_out(m_pixel_out),
        .in_range(m_in_range)
    );

endmodule
`default_nettype wire

[bench/tb_line_lens_undistort_remap_core.sv]
`timescale 1ns / 1ps
module tb_line_lens_undistort_remap_core;

    localparam int LINE_DEPTH = llur_pkg::MAX_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic        opcode;
        logic [13:0] column;
        logic [7:0]  pixel;
    } line_item_t;

    typedef struct {
        logic [7:0] pixel;
        logic       in_range;
    } remap_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = llur_pkg::REG_CENTER_COL;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = llur_pkg::OP_WRITE;
    logic [13:0] s_column = '0;
    logic [7:0]  s_pixel_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_pixel_out;
    logic        m_in_range;

    line_lens_undistort_remap_core i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_column   (s_column),
        .s_pixel_in (s_pixel_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pixel_out(m_pixel_out),
        .m_in_range (m_in_range)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow copy of the configuration registers
    logic [31:0] center_col = llur_pkg::CENTER_COL_RST;
    logic [31:0] focal_len  = llur_pkg::FOCAL_LEN_RST;
    logic [31:0] coef_cubic = '0;
    logic [31:0] coef_quintic = '0;
    logic [31:0] coef_square = '0;
    logic [14:0] line_width = llur_pkg::LINE_WIDTH_RST;

    line_item_t    pending_items[$];
    remap_result_t expected_pixels[$];
    logic [7:0]    line_pixels[LINE_DEPTH];
    bit            column_written[LINE_DEPTH];
    bit            no_idle = 0;
    int            errors = 0;
    int            send_gap = 0;
    int            sink_stall = 0;
    int            quiet_cycles = 0;

    function automatic longint unsigned mul_q28(longint unsigned a, longint unsigned b);
        return (((a >> 32) * b) << 4) + (((a & 64'hFFFF_FFFF) * b) >> 28);
    endfunction

    function automatic longint unsigned coef_magnitude(logic [31:0] k);
        logic [31:0] m;
        m = k[31] ? -k : k;
        return {32'b0, m};
    endfunction

    function automatic longint with_sign(longint unsigned mag, bit neg);
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // nearest-neighbour source column for a requested output column
    function automatic void remap_source(input logic [13:0] col, output bit ok,
                                         output int unsigned src);
        longint unsigned cq, dmag, nmag, m2, m3, m4, m5, t2, t3, t5, npmag, pmag, span;
        longint sum, np, u;
        bit dneg, nneg, npneg;
        cq = longint'(col) << 16;
        dneg = cq < {32'b0, center_col};
        dmag = dneg ? {32'b0, center_col} - cq : cq - {32'b0, center_col};
        if (dmag == 0)
            nmag = 0;
        else if (focal_len == 0)
            nmag = 64'h7FFF_FFFF;
        else begin
            nmag = (dmag << 28) / {32'b0, focal_len};
            if (nmag > 64'h7FFF_FFFF)
                nmag = 64'h7FFF_FFFF;
        end
        nneg = dneg && nmag != 0;
        m2 = mul_q28(nmag, nmag);
        m3 = mul_q28(m2, nmag);
        m4 = mul_q28(m3, nmag);
        m5 = mul_q28(m4, nmag);
        t3 = mul_q28(m3, coef_magnitude(coef_cubic));
        t5 = mul_q28(m5, coef_magnitude(coef_quintic));
        t2 = mul_q28(m2, coef_magnitude(coef_square));
        sum = with_sign(t3, coef_cubic[31] != nneg) + with_sign(t5, coef_quintic[31] != nneg)
            + with_sign(t2, coef_square[31]);
        np = with_sign(nmag, nneg) - sum;
        npneg = np < 0;
        npmag = npneg ? longint'(-np) : longint'(np);
        if (npmag > 64'h7FFF_FFFF)
            npmag = 64'h7FFF_FFFF;
        pmag = ({32'b0, focal_len} * npmag) >> 28;
        u = longint'({32'b0, center_col}) + with_sign(pmag, npneg);
        span = (line_width > LINE_DEPTH) ? LINE_DEPTH : line_width;
        ok = 0;
        src = 0;
        if (u >= 0 && (longint'(u) >>> 16) < longint'(span)) begin
            ok = 1;
            src = int'(u >>> 16);
        end
    endfunction

    task automatic queue_write(logic [13:0] col, logic [7:0] pix);
        line_item_t it;
        it.opcode = llur_pkg::OP_WRITE;
        it.column = col;
        it.pixel = pix;
        column_written[col] = 1;
        pending_items.insert(pending_items.size(), it);
    endtask

    // a request whose source was never written gets that pixel written first
    task automatic queue_read(logic [13:0] col);
        line_item_t  it;
        bit          ok;
        int unsigned src;
        remap_source(col, ok, src);
        if (ok && !column_written[src])
            queue_write(src[13:0], 8'($urandom));
        it.opcode = llur_pkg::OP_READ;
        it.column = col;
        it.pixel = 8'($urandom);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_random(int count);
        int hi;
        hi = (line_width + line_width / 8 > 16383) ? 16383 : line_width + line_width / 8;
        repeat (count) begin
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 4) != 0)
                    queue_write(14'($urandom_range(0, hi)), 8'($urandom));
                else
                    queue_write(14'($urandom), 8'($urandom));
            end else begin
                if ($urandom_range(0, 9) < 7)
                    queue_read(14'($urandom_range(0, hi)));
                else
                    queue_read(14'($urandom));
            end
        end
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            llur_pkg::REG_CENTER_COL:   center_col = value;
            llur_pkg::REG_FOCAL_LEN:    focal_len = value;
            llur_pkg::REG_COEF_CUBIC:   coef_cubic = value;
            llur_pkg::REG_COEF_QUINTIC: coef_quintic = value;
            llur_pkg::REG_COEF_SQUARE:  coef_square = value;
            llur_pkg::REG_LINE_WIDTH:   line_width = value[14:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_setting(logic [31:0] cc, logic [31:0] fl, logic [31:0] k1,
                                logic [31:0] k2, logic [31:0] k3, logic [31:0] lw);
        write_register(llur_pkg::REG_CENTER_COL, cc);
        write_register(llur_pkg::REG_FOCAL_LEN, fl);
        write_register(llur_pkg::REG_COEF_CUBIC, k1);
        write_register(llur_pkg::REG_COEF_QUINTIC, k2);
        write_register(llur_pkg::REG_COEF_SQUARE, k3);
        write_register(llur_pkg::REG_LINE_WIDTH, lw);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        // writes give no result, so let the pipeline empty
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_opcode == llur_pkg::OP_WRITE) begin
                    line_pixels[s_column] = s_pixel_in;
                end else begin
                    remap_result_t r;
                    bit            ok;
                    int unsigned   src;
                    remap_source(s_column, ok, src);
                    r.pixel = ok ? line_pixels[src] : 8'd0;
                    r.in_range = ok;
                    expected_pixels.insert(expected_pixels.size(), r);
                end
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    line_item_t it;
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_opcode <= it.opcode;
                    s_column <= it.column;
                    s_pixel_in <= it.pixel;
                    if (!no_idle && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report("unexpected result pixel_out", m_pixel_out, 8'd0);
                end else begin
                    remap_result_t r;
                    r = expected_pixels.pop_front();
                    if (m_pixel_out !== r.pixel)
                        report("pixel_out", m_pixel_out, r.pixel);
                    if (m_in_range !== r.in_range)
                        report("in_range", 8'(m_in_range), 8'(r.in_range));
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0)
                    sink_stall = $urandom_range(1, 4);
            end
        end
    end

    // watchdog on transfers while work is outstanding
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (pending_items.size() == 0 && !s_valid && expected_pixels.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting, directed corners
        queue_write(14'd0, 8'd0);
        queue_write(14'd16383, 8'd255);
        queue_write(14'd8192, 8'hA5);
        queue_write(14'h2AAA, 8'h5A);
        queue_write(14'h1555, 8'hFF);
        queue_read(14'd0);
        queue_read(14'd16383);
        queue_read(14'd8192);
        queue_read(14'h2AAA);
        queue_read(14'h1555);
        queue_write(14'd0, 8'd255);
        queue_read(14'd0);
        queue_random(200);
        wait_idle();

        // unit focal length, small mixed-sign terms, narrow line
        load_setting(32'h0100_0000, 32'h0001_0000, 32'h0010_0000, -32'sh0001_0000,
                     32'h0008_0000, 32'd512);
        queue_read(14'd256);
        queue_read(14'd255);
        queue_read(14'd511);
        queue_read(14'd512);
        queue_random(220);
        wait_idle();

        // every register but the line width at its top end, one column wide
        load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'd1);
        queue_read(14'd0);
        queue_read(14'd16383);
        queue_random(200);
        wait_idle();

        // strong square term against negative cubic
        load_setting(32'h0080_0000, 32'd200 << 16, -32'sh0200_0000, 32'h0100_0000,
                     32'h7FFF_FFFF, 32'd300);
        queue_random(220);
        wait_idle();

        // centre at column zero, full line
        load_setting(32'h0000_0000, 32'd1000 << 16, 32'h0040_0000, 32'h0,
                     -32'sh0020_0000, 32'd16384);
        queue_read(14'd0);
        queue_random(220);
        wait_idle();

        // barrel correction on a short line, no idling
        no_idle = 1;
        load_setting(32'd64 << 16, 32'd128 << 16, 32'h0800_0000, 32'h0400_0000,
                     32'h0, 32'd128);
        queue_random(240);
        wait_idle();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
